// ===== src/sfasmd_pkg.sv =====
package sfasmd_pkg;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_SUB = 2'd1;
	localparam logic [1:0] KIND_MUL = 2'd2;
	localparam logic [1:0] KIND_DIV = 2'd3;

	localparam logic [31:0] POS_ZERO = 32'h0000_0000;
	localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
	localparam logic [31:0] POS_INF  = 32'h7f80_0000;
	localparam logic [31:0] NEG_INF  = 32'hff80_0000;
	localparam logic [31:0] POS_NAN  = 32'h7fc0_0000;
	localparam logic [31:0] NEG_NAN  = 32'hffc0_0000;

	localparam logic [7:0] EXP_ALL_ONES = 8'hff;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_MUL,
		OP_DIV
	} op_t;

	// special: opa carries the finished result word
	typedef struct packed {
		logic        special;
		op_t         op;
		logic [31:0] opa;
		logic [31:0] opb;
	} item_t;

endpackage

// ===== src/sfasmd_front.sv =====
module sfasmd_front (
	input  logic [1:0]           kind,
	input  logic [31:0]          operand_a,
	input  logic [31:0]          operand_b,
	output sfasmd_pkg::item_t    item
);

	logic [31:0] a, b, bs;
	logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
	logic        bs_zero, bs_inf, bs_nan;
	logic        s;
	logic        any_pnan;

	assign a  = operand_a;
	assign b  = operand_b;
	assign bs = (kind == sfasmd_pkg::KIND_SUB) ? {~b[31], b[30:0]} : b;

	assign a_zero  = (a == sfasmd_pkg::POS_ZERO) || (a == sfasmd_pkg::NEG_ZERO);
	assign b_zero  = (b == sfasmd_pkg::POS_ZERO) || (b == sfasmd_pkg::NEG_ZERO);
	assign a_inf   = (a == sfasmd_pkg::POS_INF) || (a == sfasmd_pkg::NEG_INF);
	assign b_inf   = (b == sfasmd_pkg::POS_INF) || (b == sfasmd_pkg::NEG_INF);
	assign a_nan   = (a == sfasmd_pkg::POS_NAN) || (a == sfasmd_pkg::NEG_NAN);
	assign b_nan   = (b == sfasmd_pkg::POS_NAN) || (b == sfasmd_pkg::NEG_NAN);
	assign bs_zero = (bs == sfasmd_pkg::POS_ZERO) || (bs == sfasmd_pkg::NEG_ZERO);
	assign bs_inf  = (bs == sfasmd_pkg::POS_INF) || (bs == sfasmd_pkg::NEG_INF);
	assign bs_nan  = (bs == sfasmd_pkg::POS_NAN) || (bs == sfasmd_pkg::NEG_NAN);
	assign s        = a[31] ^ b[31];
	assign any_pnan = (a == sfasmd_pkg::POS_NAN) || (b == sfasmd_pkg::POS_NAN);

	always_comb begin
		item.special = 1'b1;
		item.op      = sfasmd_pkg::OP_ADD;
		item.opa     = a;
		item.opb     = bs;
		unique case (kind) inside
			sfasmd_pkg::KIND_ADD, sfasmd_pkg::KIND_SUB: begin
				if (kind == sfasmd_pkg::KIND_SUB && a_zero && b_zero) begin
					item.opa = a & ~b;
				end else if (kind == sfasmd_pkg::KIND_SUB && a_nan && b_nan) begin
					item.opa = a & b;
				end else if (kind == sfasmd_pkg::KIND_SUB && a_nan) begin
					item.opa = a;
				end else if (kind == sfasmd_pkg::KIND_SUB && b_nan) begin
					item.opa = b;
				end else if (a_zero && bs_zero) begin
					item.opa = a & bs;
				end else if (a_inf && bs_inf && a != bs) begin
					item.opa = sfasmd_pkg::NEG_NAN;
				end else if ((a_inf && bs_nan) ||
						(a == sfasmd_pkg::NEG_NAN && bs == sfasmd_pkg::POS_NAN)) begin
					item.opa = bs;
				end else if (a_zero) begin
					item.opa = bs;
				end else if (bs_zero) begin
					item.opa = a;
				end else if (a[30:23] == sfasmd_pkg::EXP_ALL_ONES) begin
					item.opa = a;
				end else if (bs[30:23] == sfasmd_pkg::EXP_ALL_ONES) begin
					item.opa = bs;
				end else begin
					item.special = 1'b0;
				end
			end
			sfasmd_pkg::KIND_MUL: begin
				item.op = sfasmd_pkg::OP_MUL;
				if ((a_zero && b_inf) || (a_inf && b_zero)) begin
					item.opa = sfasmd_pkg::NEG_NAN;
				end else if (a_nan || b_nan) begin
					item.opa = any_pnan ? sfasmd_pkg::POS_NAN : sfasmd_pkg::NEG_NAN;
				end else if (a_zero || b_zero) begin
					item.opa = {s, 31'b0};
				end else if (a_inf || b_inf) begin
					item.opa = {s, sfasmd_pkg::POS_INF[30:0]};
				end else begin
					item.special = 1'b0;
				end
			end
			default: begin
				item.op = sfasmd_pkg::OP_DIV;
				if ((a_zero && b_zero) || (a_inf && b_inf)) begin
					item.opa = sfasmd_pkg::NEG_NAN;
				end else if (a_inf && b_zero) begin
					item.opa = {s, sfasmd_pkg::POS_INF[30:0]};
				end else if (a_nan || b_nan) begin
					item.opa = any_pnan ? sfasmd_pkg::POS_NAN : sfasmd_pkg::NEG_NAN;
				end else if (a_inf || b_zero) begin
					item.opa = {s, sfasmd_pkg::POS_INF[30:0]};
				end else if (a_zero || b_inf) begin
					item.opa = {s, 31'b0};
				end else begin
					item.special = 1'b0;
				end
			end
		endcase
	end

endmodule

// ===== src/sfasmd_queue.sv =====
module sfasmd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	input  sfasmd_pkg::item_t    wr_data,
	output logic                 full,
	output logic                 rd_valid,
	input  logic                 rd_take,
	output sfasmd_pkg::item_t    rd_data
);

	sfasmd_pkg::item_t mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;
	logic       do_wr, do_rd;

	assign full     = (count_q == 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];
	assign do_wr    = wr_valid && !full;
	assign do_rd    = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= ~wptr_q;
			end
			if (do_rd) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule

// ===== src/sfasmd_back.sv =====
module sfasmd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_valid,
	input  sfasmd_pkg::item_t    rd_data,
	output logic                 rd_take,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          result
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DNORM,
		S_DIV,
		S_NORM,
		S_ROUND,
		S_FINISH
	} state_t;

	state_t             state_q;
	sfasmd_pkg::op_t    op_q;
	logic [31:0]        a_q, b_q, res_q;
	logic               sign_q;
	logic signed [11:0] exp_q;
	logic [47:0]        sig_q;
	logic [24:0]        rem_q;
	logic [23:0]        den_q;
	logic [4:0]         cnt_q;

	// operand decode
	logic [7:0]  ea, eb, ehi, elo, exp_gap;
	logic [23:0] ma, mb, mhi, mlo;
	logic        a_big, shi, slo;
	logic [53:0] wide, shf;
	logic [26:0] big, aligned;
	logic [27:0] mag;
	logic        mag_sign;
	logic [47:0] prod;

	// divider step
	logic        ge;
	logic [24:0] diff;

	// rounding
	logic [23:0]        m, mfin;
	logic [2:0]         grs;
	logic               inc, carry, ovf;
	logic [24:0]        m25;
	logic signed [11:0] exp_r;
	logic [31:0]        rounded;

	assign ea = (a_q[30:23] == 8'd0) ? 8'd1 : a_q[30:23];
	assign eb = (b_q[30:23] == 8'd0) ? 8'd1 : b_q[30:23];
	assign ma = {|a_q[30:23], a_q[22:0]};
	assign mb = {|b_q[30:23], b_q[22:0]};

	assign a_big   = ea > eb;
	assign ehi     = a_big ? ea : eb;
	assign elo     = a_big ? eb : ea;
	assign mhi     = a_big ? ma : mb;
	assign mlo     = a_big ? mb : ma;
	assign shi     = a_big ? a_q[31] : b_q[31];
	assign slo     = a_big ? b_q[31] : a_q[31];
	assign exp_gap = ehi - elo;
	assign wide    = {mlo, 3'b000, 27'b0};
	assign shf     = wide >> exp_gap[4:0];
	assign big     = {mhi, 3'b000};

	always_comb begin
		if (exp_gap >= 8'd27) begin
			aligned = {26'b0, |mlo};
		end else begin
			aligned = shf[53:27] | {26'b0, |shf[26:0]};
		end
		if (shi == slo) begin
			mag      = {1'b0, big} + {1'b0, aligned};
			mag_sign = shi;
		end else if (big >= aligned) begin
			mag      = {1'b0, big - aligned};
			mag_sign = shi;
		end else begin
			mag      = {1'b0, aligned - big};
			mag_sign = slo;
		end
	end

	assign prod = ma * mb;

	assign ge   = rem_q >= {1'b0, den_q};
	assign diff = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	assign m     = sig_q[26:3];
	assign grs   = sig_q[2:0];
	assign inc   = (grs > 3'd4) || ((grs == 3'd4) && m[0]);
	assign m25   = {1'b0, m} + 25'(inc);
	assign carry = m25[24];
	assign exp_r = exp_q + (carry ? 12'sd1 : 12'sd0);
	assign mfin  = carry ? m25[24:1] : m25[23:0];
	assign ovf   = (exp_q >= 12'sd255) || (exp_r >= 12'sd255);
	assign rounded = ovf ? {sign_q, sfasmd_pkg::POS_INF[30:0]}
		: {sign_q, (mfin[23] ? exp_r[7:0] : 8'd0), mfin[22:0]};

	assign rd_take = (state_q == S_IDLE) && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			result    <= '0;
			op_q      <= sfasmd_pkg::OP_ADD;
			a_q       <= '0;
			b_q       <= '0;
			res_q     <= '0;
			sign_q    <= 1'b0;
			exp_q     <= '0;
			sig_q     <= '0;
			rem_q     <= '0;
			den_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (out_valid && !out_stall && state_q != S_FINISH) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rd_valid) begin
						op_q <= rd_data.op;
						a_q  <= rd_data.opa;
						b_q  <= rd_data.opb;
						if (rd_data.special) begin
							res_q   <= rd_data.opa;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					unique case (op_q)
						sfasmd_pkg::OP_ADD: begin
							sign_q  <= mag_sign;
							exp_q   <= $signed({4'b0, ehi});
							sig_q   <= {20'b0, mag};
							state_q <= S_NORM;
						end
						sfasmd_pkg::OP_MUL: begin
							sign_q  <= a_q[31] ^ b_q[31];
							exp_q   <= $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd147;
							sig_q   <= prod;
							state_q <= S_NORM;
						end
						default: begin
							sign_q  <= a_q[31] ^ b_q[31];
							exp_q   <= $signed({4'b0, ea}) - $signed({4'b0, eb}) + 12'sd125;
							rem_q   <= {1'b0, ma};
							den_q   <= mb;
							state_q <= S_DNORM;
						end
					endcase
				end
				S_DNORM: begin
					if (!rem_q[23]) begin
						rem_q <= {rem_q[23:0], 1'b0};
						exp_q <= exp_q - 12'sd1;
					end else if (!den_q[23]) begin
						den_q <= {den_q[22:0], 1'b0};
						exp_q <= exp_q + 12'sd1;
					end else begin
						sig_q   <= '0;
						cnt_q   <= 5'd28;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= {diff[23:0], 1'b0};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						sig_q   <= {sig_q[46:0], ge | (|diff)};
						state_q <= S_NORM;
					end else begin
						sig_q <= {sig_q[46:0], ge};
					end
				end
				S_NORM: begin
					if (sig_q == 48'd0) begin
						res_q   <= sfasmd_pkg::POS_ZERO;
						state_q <= S_FINISH;
					end else if (|sig_q[47:27]) begin
						sig_q <= {1'b0, sig_q[47:2], sig_q[1] | sig_q[0]};
						exp_q <= exp_q + 12'sd1;
					end else if (!sig_q[26] && exp_q > 12'sd1) begin
						sig_q <= {sig_q[46:0], 1'b0};
						exp_q <= exp_q - 12'sd1;
					end else if (exp_q < -12'sd60) begin
						sig_q <= 48'd1;
						exp_q <= 12'sd1;
					end else if (exp_q < 12'sd1) begin
						sig_q <= {1'b0, sig_q[47:2], sig_q[1] | sig_q[0]};
						exp_q <= exp_q + 12'sd1;
					end else begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					res_q   <= rounded;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid || !out_stall) begin
						result    <= res_q;
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== src/single_float_add_sub_mul_div.sv =====
// Zero, infinity and NaN cases are resolved in the front end and skip the back-end
// arithmetic; add/sub, multiply and divide pass through the one-bit-per-cycle
// normalize loop, and divide also through the 29-step restoring divider in the back end.
// The back end works on one transaction at a time; a two-entry queue takes new
// transactions while the back end works. Reset clears queue and control state.
module single_float_add_sub_mul_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result
);

	sfasmd_pkg::item_t front_item, q_item;
	logic              q_full, q_valid, q_take;

	sfasmd_front u_front (
		.kind      (kind),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.item      (front_item)
	);

	sfasmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_data  (front_item),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_take  (q_take),
		.rd_data  (q_item)
	);

	sfasmd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_valid  (q_valid),
		.rd_data   (q_item),
		.rd_take   (q_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign in_stall = q_full;

endmodule

// ===== src/sfasmd_checker.sv =====
module sfasmd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("stalled result changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall without a prior transaction");

	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(arst_n, 2))
		else $error("result too soon after reset");

endmodule

bind single_float_add_sub_mul_div sfasmd_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.result    (result)
);

// ===== tb/single_float_add_sub_mul_div_tb.sv =====
`timescale 1ns / 100ps

module single_float_add_sub_mul_div_tb;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_ITEMS = 1000;
	localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] a;
		logic [31:0] b;
	} fp_req_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] result;

	fp_req_t     pending_reqs[$];
	logic [31:0] expected_words[$];
	int          fail_count;
	int          checked_count;
	int          idle_cycles;
	int          burst_left;
	int          gap_left;
	int          stall_phase;
	bit          hold_for_drain;
	bit          stim_done;
	bit          in_accepted;
	int          kind_seen[4];

	single_float_add_sub_mul_div dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result(result)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit fp_is_zero(logic [31:0] w);
		return w == sfasmd_pkg::POS_ZERO || w == sfasmd_pkg::NEG_ZERO;
	endfunction

	function automatic bit fp_is_inf(logic [31:0] w);
		return w == sfasmd_pkg::POS_INF || w == sfasmd_pkg::NEG_INF;
	endfunction

	function automatic bit fp_is_nan(logic [31:0] w);
		return w == sfasmd_pkg::POS_NAN || w == sfasmd_pkg::NEG_NAN;
	endfunction

	function automatic logic [23:0] fp_mant(logic [31:0] w);
		return (w[30:23] != 8'd0) ? {1'b1, w[22:0]} : {1'b0, w[22:0]};
	endfunction

	function automatic int fp_exp(logic [31:0] w);
		return (w[30:23] == 8'd0) ? 1 : int'(w[30:23]);
	endfunction

	function automatic logic [63:0] shift_sticky(logic [63:0] v, int k);
		if (k <= 0)
			return v;
		if (k >= 64)
			return {63'd0, |v};
		return (v >> k) | {63'd0, |(v & ((64'd1 << k) - 64'd1))};
	endfunction

	function automatic logic [31:0] round_pack(logic sgn, int e, logic [63:0] m);
		int p;
		int k;
		logic [2:0] grs;
		if (m == 64'd0)
			return {sgn, 31'd0};
		p = 63;
		while (!m[p])
			p--;
		if (p > 26) begin
			m = shift_sticky(m, p - 26);
			e += p - 26;
		end else if (p < 26 && e > 1) begin
			k = 26 - p;
			if (k > e - 1)
				k = e - 1;
			m = m << k;
			e -= k;
		end
		if (e < 1) begin
			m = shift_sticky(m, 1 - e);
			e = 1;
		end
		if (e >= 255)
			return {sgn, 31'd0} | sfasmd_pkg::POS_INF;
		grs = m[2:0];
		m = m >> 3;
		if (grs > 3'd4 || (grs == 3'd4 && m[0]))
			m++;
		if (m[24]) begin
			m = m >> 1;
			e++;
			if (e >= 255)
				return {sgn, 31'd0} | sfasmd_pkg::POS_INF;
		end
		return {sgn, (m[23] ? 8'(e) : 8'd0), m[22:0]};
	endfunction

	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic [31:0] lo;
		logic [31:0] hi;
		logic signed [65:0] vlo;
		logic signed [65:0] vhi;
		logic signed [65:0] total;
		if (a == sfasmd_pkg::POS_ZERO && b == sfasmd_pkg::POS_ZERO)
			return sfasmd_pkg::POS_ZERO;
		if (a == sfasmd_pkg::NEG_ZERO && b == sfasmd_pkg::POS_ZERO)
			return sfasmd_pkg::POS_ZERO;
		if (a == sfasmd_pkg::POS_ZERO && b == sfasmd_pkg::NEG_ZERO)
			return sfasmd_pkg::POS_ZERO;
		if (a == sfasmd_pkg::NEG_ZERO && b == sfasmd_pkg::NEG_ZERO)
			return sfasmd_pkg::NEG_ZERO;
		if (fp_is_inf(a) && fp_is_inf(b) && a != b) return sfasmd_pkg::NEG_NAN;
		if (fp_is_inf(a) && fp_is_nan(b)) return b;
		if (a == sfasmd_pkg::NEG_NAN && b == sfasmd_pkg::POS_NAN) return sfasmd_pkg::POS_NAN;
		if (fp_is_zero(a)) return b;
		if (fp_is_zero(b)) return a;
		if (a[30:23] == sfasmd_pkg::EXP_ALL_ONES) return a;
		if (b[30:23] == sfasmd_pkg::EXP_ALL_ONES) return b;
		if (fp_exp(a) > fp_exp(b)) begin
			lo = b;
			hi = a;
		end else begin
			lo = a;
			hi = b;
		end
		vlo = $signed({2'b00, shift_sticky({37'd0, fp_mant(lo), 3'd0},
			fp_exp(hi) - fp_exp(lo))});
		vhi = $signed({2'b00, 37'd0, fp_mant(hi), 3'd0});
		if (lo[31]) vlo = -vlo;
		if (hi[31]) vhi = -vhi;
		total = vlo + vhi;
		if (total < 0)
			return round_pack(1'b1, fp_exp(hi), 64'(-total));
		return round_pack(1'b0, fp_exp(hi), 64'(total));
	endfunction

	function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
		if (a == sfasmd_pkg::POS_ZERO && b == sfasmd_pkg::POS_ZERO)
			return sfasmd_pkg::POS_ZERO;
		if (a == sfasmd_pkg::NEG_ZERO && b == sfasmd_pkg::POS_ZERO)
			return sfasmd_pkg::NEG_ZERO;
		if (a == sfasmd_pkg::POS_ZERO && b == sfasmd_pkg::NEG_ZERO)
			return sfasmd_pkg::POS_ZERO;
		if (a == sfasmd_pkg::NEG_ZERO && b == sfasmd_pkg::NEG_ZERO)
			return sfasmd_pkg::POS_ZERO;
		if (fp_is_nan(a) && fp_is_nan(b))
			return (a == sfasmd_pkg::NEG_NAN && b == sfasmd_pkg::NEG_NAN)
				? sfasmd_pkg::NEG_NAN : sfasmd_pkg::POS_NAN;
		if (fp_is_nan(a)) return a;
		if (fp_is_nan(b)) return b;
		return fp_add(a, b ^ SIGN_MASK);
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic sgn;
		sgn = a[31] ^ b[31];
		if ((fp_is_zero(a) && fp_is_inf(b)) || (fp_is_inf(a) && fp_is_zero(b)))
			return sfasmd_pkg::NEG_NAN;
		if (fp_is_nan(a) || fp_is_nan(b))
			return (a == sfasmd_pkg::POS_NAN || b == sfasmd_pkg::POS_NAN)
				? sfasmd_pkg::POS_NAN : sfasmd_pkg::NEG_NAN;
		if (fp_is_zero(a) || fp_is_zero(b)) return {sgn, 31'd0};
		if (fp_is_inf(a) || fp_is_inf(b)) return {sgn, 31'd0} | sfasmd_pkg::POS_INF;
		return round_pack(sgn, fp_exp(a) + fp_exp(b) - 127 - 23 + 3,
			64'(fp_mant(a)) * 64'(fp_mant(b)));
	endfunction

	function automatic logic [31:0] fp_div(logic [31:0] a, logic [31:0] b);
		logic sgn;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] quo;
		int sh;
		sgn = a[31] ^ b[31];
		sh = 0;
		if (fp_is_zero(a) && fp_is_zero(b)) return sfasmd_pkg::NEG_NAN;
		if (fp_is_inf(a) && fp_is_inf(b)) return sfasmd_pkg::NEG_NAN;
		if (fp_is_inf(a) && fp_is_zero(b)) return {sgn, 31'd0} | sfasmd_pkg::POS_INF;
		if (fp_is_nan(a) || fp_is_nan(b))
			return (a == sfasmd_pkg::POS_NAN || b == sfasmd_pkg::POS_NAN)
				? sfasmd_pkg::POS_NAN : sfasmd_pkg::NEG_NAN;
		if (fp_is_inf(a) || fp_is_zero(b)) return {sgn, 31'd0} | sfasmd_pkg::POS_INF;
		if (fp_is_zero(a) || fp_is_inf(b)) return {sgn, 31'd0};
		num = 64'(fp_mant(a));
		den = 64'(fp_mant(b));
		while (!num[63]) begin
			num = num << 1;
			sh++;
		end
		while (!den[0]) begin
			den = den >> 1;
			sh++;
		end
		quo = num / den;
		if (num % den != 0)
			quo[0] = 1'b1;
		return round_pack(sgn, fp_exp(a) - fp_exp(b) + 127 - (sh - 26), quo);
	endfunction

	function automatic logic [31:0] fp_compute(fp_req_t r);
		case (r.kind)
			sfasmd_pkg::KIND_ADD: return fp_add(r.a, r.b);
			sfasmd_pkg::KIND_SUB: return fp_sub(r.a, r.b);
			sfasmd_pkg::KIND_MUL: return fp_mul(r.a, r.b);
			default:  return fp_div(r.a, r.b);
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0: w = sfasmd_pkg::POS_ZERO | (w & SIGN_MASK);
			1: w = sfasmd_pkg::POS_INF | (w & SIGN_MASK);
			2: w = $urandom_range(0, 1) ? sfasmd_pkg::POS_NAN : sfasmd_pkg::NEG_NAN;
			3: w[30:23] = 8'd0;
			4: w[30:23] = 8'($urandom_range(0, 3));
			5: w[30:23] = 8'($urandom_range(250, 255));
			default: w = w;
		endcase
		return w;
	endfunction

	task automatic push_req(logic [1:0] k, logic [31:0] a, logic [31:0] b);
		fp_req_t r;
		r.kind = k;
		r.a = a;
		r.b = b;
		pending_reqs.push_back(r);
	endtask

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_accepted)) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 30);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
			end
			if (pending_reqs.size() == 0 || hold_for_drain
					|| (gap_left > 0 && in_valid == 1'b0)) begin
				in_valid <= 1'b0;
				if (gap_left > 0 && !hold_for_drain && pending_reqs.size() != 0)
					gap_left--;
			end else if (gap_left > 0 && burst_left == 0) begin
				in_valid <= 1'b0;
			end else begin
				fp_req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				kind <= r.kind;
				operand_a <= r.a;
				operand_b <= r.b;
				if (burst_left > 0)
					burst_left--;
			end
		end
		stall_phase++;
		case ((stall_phase / 64) % 4)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) < 8);
		endcase
	end

	// monitor
	always @(posedge clk) begin
		in_accepted = in_valid && !in_stall;
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && !in_stall) begin
				fp_req_t r;
				r.kind = kind;
				r.a = operand_a;
				r.b = operand_b;
				expected_words.push_back(fp_compute(r));
				kind_seen[kind]++;
				idle_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				if (expected_words.size() == 0) begin
					$error("result with no transaction pending: %h", result);
					fail_count++;
				end else begin
					logic [31:0] want;
					want = expected_words.pop_front();
					checked_count++;
					if (result !== want) begin
						$error("result mismatch: expected %h actual %h", want, result);
						fail_count++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout with %0d results outstanding", expected_words.size());
				$display("single_float_add_sub_mul_div_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] edge_words[10];
		int n;
		in_valid = 1'b0;
		out_stall = 1'b0;
		kind = sfasmd_pkg::KIND_ADD;
		operand_a = '0;
		operand_b = '0;
		arst_n = 1'b0;
		fail_count = 0;
		checked_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		gap_left = 0;
		stall_phase = 0;
		hold_for_drain = 1'b0;
		stim_done = 1'b0;
		in_accepted = 1'b0;
		edge_words = '{sfasmd_pkg::POS_ZERO, sfasmd_pkg::NEG_ZERO, sfasmd_pkg::POS_INF,
			sfasmd_pkg::NEG_INF, sfasmd_pkg::POS_NAN, sfasmd_pkg::NEG_NAN,
			32'h0000_0001, 32'h7f7f_ffff, 32'h3f80_0000, 32'h7fa0_0001};

		push_req(sfasmd_pkg::KIND_ADD, sfasmd_pkg::POS_INF, sfasmd_pkg::NEG_INF);
		push_req(sfasmd_pkg::KIND_SUB, sfasmd_pkg::POS_INF, sfasmd_pkg::POS_INF);
		push_req(sfasmd_pkg::KIND_ADD, sfasmd_pkg::NEG_NAN, sfasmd_pkg::POS_NAN);
		push_req(sfasmd_pkg::KIND_SUB, sfasmd_pkg::NEG_NAN, sfasmd_pkg::NEG_NAN);
		push_req(sfasmd_pkg::KIND_SUB, sfasmd_pkg::NEG_ZERO, sfasmd_pkg::POS_ZERO);
		push_req(sfasmd_pkg::KIND_ADD, 32'h3f80_0000, 32'hbf80_0000);
		push_req(sfasmd_pkg::KIND_MUL, sfasmd_pkg::NEG_ZERO, sfasmd_pkg::POS_INF);
		push_req(sfasmd_pkg::KIND_MUL, 32'h7f7f_ffff, 32'h4000_0000);
		push_req(sfasmd_pkg::KIND_MUL, 32'h0080_0000, 32'h3f00_0000);
		push_req(sfasmd_pkg::KIND_MUL, 32'h0000_0001, 32'h3f00_0000);
		push_req(sfasmd_pkg::KIND_MUL, 32'h7fa0_0001, 32'h3f80_0000);
		push_req(sfasmd_pkg::KIND_DIV, sfasmd_pkg::POS_ZERO, sfasmd_pkg::NEG_ZERO);
		push_req(sfasmd_pkg::KIND_DIV, sfasmd_pkg::NEG_INF, sfasmd_pkg::POS_ZERO);
		push_req(sfasmd_pkg::KIND_DIV, sfasmd_pkg::POS_INF, sfasmd_pkg::NEG_INF);
		push_req(sfasmd_pkg::KIND_DIV, 32'h3f80_0000, sfasmd_pkg::NEG_ZERO);
		push_req(sfasmd_pkg::KIND_DIV, 32'h3f80_0000, 32'h4040_0000);
		push_req(sfasmd_pkg::KIND_DIV, 32'h0000_0001, 32'h7f7f_ffff);
		push_req(sfasmd_pkg::KIND_ADD, 32'h3380_0000, 32'h3f80_0000);
		push_req(sfasmd_pkg::KIND_ADD, 32'hffff_ffff, 32'h0000_0001);
		push_req(sfasmd_pkg::KIND_SUB, 32'h0080_0000, 32'h007f_ffff);
		for (int i = 0; i < 4; i++)
			push_req(2'(i), edge_words[$urandom_range(0, 9)],
				edge_words[$urandom_range(0, 9)]);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			push_req(2'($urandom_range(0, 3)), rand_word(), rand_word());
			if (n == RANDOM_ITEMS / 2) begin
				while (pending_reqs.size() != 0)
					@(posedge clk);
				hold_for_drain = 1'b1;
				while (expected_words.size() != 0 || in_valid)
					@(posedge clk);
				hold_for_drain = 1'b0;
			end
		end
		while (pending_reqs.size() != 0 || (in_valid && in_stall))
			@(posedge clk);
		@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d results: add %0d, sub %0d, mul %0d, div %0d",
			checked_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("zeros, infinities, NaNs, denormals and overflow mixed in");
		if (fail_count == 0)
			$display("single_float_add_sub_mul_div_tb OK");
		else
			$display("single_float_add_sub_mul_div_tb NOT OK");
		$finish;
	end

endmodule
